// File: rtl/core/svn_pkg.sv
// Shared constants, codes, types and functions of the smooth vertex normal unit.
`timescale 1ns / 1ps
`default_nettype none
package svn_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int IDX_CAP          = 1024;
  localparam int IDX_W            = 10;
  localparam int CNT_W            = 11;
  localparam int POS_W            = 16;
  localparam int NRM_W            = 16;
  localparam int SUM_W            = 32;
  localparam int VEC_W            = 36;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TRI   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_ERR  = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } vec16_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] z;
  } sum_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [1:0] status;
    vec16_t     nrm;
  } norm_res_t;

  // Signed 32-bit accumulate that clamps at both ends of the range.
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [NRM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W-NRM_W+1){b[NRM_W-1]}}, b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/svn_if.sv
// Valid/ready channel interfaces for the input and result items.
`timescale 1ns / 1ps
`default_nettype none
interface svn_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       command;
  logic signed [svn_pkg::POS_W-1:0] pos_x;
  logic signed [svn_pkg::POS_W-1:0] pos_y;
  logic signed [svn_pkg::POS_W-1:0] pos_z;
  logic [svn_pkg::IDX_W-1:0]        corner_a;
  logic [svn_pkg::IDX_W-1:0]        corner_b;
  logic [svn_pkg::IDX_W-1:0]        corner_c;

  modport source (output valid, command, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
                  input ready);
  modport sink (input valid, command, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
                output ready);
endinterface

interface svn_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic signed [svn_pkg::NRM_W-1:0] normal_x;
  logic signed [svn_pkg::NRM_W-1:0] normal_y;
  logic signed [svn_pkg::NRM_W-1:0] normal_z;
  logic [svn_pkg::IDX_W-1:0]        assigned_index;

  modport source (output valid, status, normal_x, normal_y, normal_z, assigned_index,
                  input ready);
  modport sink (input valid, status, normal_x, normal_y, normal_z, assigned_index,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/smooth_vertex_normals_unit.sv
// Most of the time from acceptance to the result goes to the normaliser's search per component,
// plus the right shifts of an over-long vector. Throughput: one item at a time; the next item
// is taken at the edge after the result enters the output register, which may still wait to be
// taken. Reset clears the vertex count and control state only: each load zeroes the running sum
// of its vertex, so no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module smooth_vertex_normals_unit #(
  parameter int MAX_VERTICES = svn_pkg::MAX_VERTICES_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  svn_in_if.sink   in_ch,
  svn_out_if.source out_ch
);

  localparam int VCAP = (MAX_VERTICES < svn_pkg::IDX_CAP) ? MAX_VERTICES : svn_pkg::IDX_CAP;
  localparam int AW   = $clog2(VCAP);
  localparam int CW   = svn_pkg::CNT_W;
  localparam int IW   = svn_pkg::IDX_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LOAD  = 5'd1;
  localparam logic [4:0] S_TRA   = 5'd2;
  localparam logic [4:0] S_TRB   = 5'd3;
  localparam logic [4:0] S_TRC   = 5'd4;
  localparam logic [4:0] S_TRD   = 5'd5;
  localparam logic [4:0] S_CROSS = 5'd6;
  localparam logic [4:0] S_TNORM = 5'd7;
  localparam logic [4:0] S_URA   = 5'd8;
  localparam logic [4:0] S_UWA   = 5'd9;
  localparam logic [4:0] S_URB   = 5'd10;
  localparam logic [4:0] S_UWB   = 5'd11;
  localparam logic [4:0] S_URC   = 5'd12;
  localparam logic [4:0] S_UWC   = 5'd13;
  localparam logic [4:0] S_QRD   = 5'd14;
  localparam logic [4:0] S_QCAP  = 5'd15;
  localparam logic [4:0] S_QNORM = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0]            state_r;
  logic [CW-1:0]         cnt_r;
  svn_pkg::vec16_t       pos_r;
  logic [IW-1:0]         ca_r;
  logic [IW-1:0]         cb_r;
  logic [IW-1:0]         cc_r;
  svn_pkg::vec16_t       pa_r;
  svn_pkg::vec16_t       pb_r;
  logic [1:0]            rstat_r;
  svn_pkg::vec16_t       rn_r;
  logic [IW-1:0]         rasg_r;
  logic                  out_valid_r;
  logic [1:0]            ostat_r;
  svn_pkg::vec16_t       on_r;
  logic [IW-1:0]         oasg_r;

  logic                  accept;
  logic                  out_free;
  logic                  tri_ok;
  logic                  qry_ok;
  logic                  idle_err;
  logic                  pos_we;
  logic [AW-1:0]         pos_raddr;
  logic [3*svn_pkg::POS_W-1:0] pos_rdata;
  svn_pkg::vec16_t       pos_rd;
  logic                  sum_we;
  logic [AW-1:0]         sum_waddr;
  logic [AW-1:0]         sum_raddr;
  svn_pkg::sum_t         sum_wd;
  logic [3*svn_pkg::SUM_W-1:0] sum_rdata;
  svn_pkg::sum_t         sum_rd;
  svn_pkg::sum_t         sum_upd;
  logic                  cross_start;
  logic                  cross_done;
  svn_pkg::vec_t         cross_vec;
  logic                  norm_start;
  svn_pkg::vec_t         norm_vec;
  logic                  norm_done;
  svn_pkg::norm_res_t    norm_res;
  svn_pkg::vec_t         sum_vec;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign pos_rd   = svn_pkg::vec16_t'(pos_rdata);
  assign sum_rd   = svn_pkg::sum_t'(sum_rdata);

  assign tri_ok   = ({1'b0, in_ch.corner_a} < cnt_r) && ({1'b0, in_ch.corner_b} < cnt_r) &&
                    ({1'b0, in_ch.corner_c} < cnt_r);
  assign qry_ok   = ({1'b0, in_ch.corner_a} < cnt_r);
  assign idle_err = ((in_ch.command == svn_pkg::CMD_TRI) && !tri_ok) ||
                    ((in_ch.command == svn_pkg::CMD_QUERY) && !qry_ok);

  assign sum_upd.x = svn_pkg::sat_add(sum_rd.x, rn_r.x);
  assign sum_upd.y = svn_pkg::sat_add(sum_rd.y, rn_r.y);
  assign sum_upd.z = svn_pkg::sat_add(sum_rd.z, rn_r.z);

  assign sum_vec.x = {{(svn_pkg::VEC_W-svn_pkg::SUM_W){sum_rd.x[svn_pkg::SUM_W-1]}}, sum_rd.x};
  assign sum_vec.y = {{(svn_pkg::VEC_W-svn_pkg::SUM_W){sum_rd.y[svn_pkg::SUM_W-1]}}, sum_rd.y};
  assign sum_vec.z = {{(svn_pkg::VEC_W-svn_pkg::SUM_W){sum_rd.z[svn_pkg::SUM_W-1]}}, sum_rd.z};

  assign pos_we      = (state_r == S_LOAD) && (cnt_r != CW'(VCAP));
  assign cross_start = (state_r == S_TRD);
  assign norm_start  = ((state_r == S_CROSS) && cross_done) || (state_r == S_QCAP);
  assign norm_vec    = (state_r == S_QCAP) ? sum_vec : cross_vec;

  always_comb begin
    case (state_r)
      S_TRB:   pos_raddr = cb_r[AW-1:0];
      S_TRC:   pos_raddr = cc_r[AW-1:0];
      default: pos_raddr = ca_r[AW-1:0];
    endcase
  end

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = ca_r[AW-1:0];
    sum_wd    = sum_upd;
    case (state_r)
      S_LOAD: begin
        sum_we    = pos_we;
        sum_waddr = cnt_r[AW-1:0];
        sum_wd    = '0;
      end
      S_UWA: sum_we = 1'b1;
      S_UWB: begin
        sum_we    = 1'b1;
        sum_waddr = cb_r[AW-1:0];
      end
      S_UWC: begin
        sum_we    = 1'b1;
        sum_waddr = cc_r[AW-1:0];
      end
      default: sum_we = 1'b0;
    endcase
  end

  always_comb begin
    case (state_r)
      S_URB:   sum_raddr = cb_r[AW-1:0];
      S_URC:   sum_raddr = cc_r[AW-1:0];
      default: sum_raddr = ca_r[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In the done state a free output register is refilled, so it is not emptied there.
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            pos_r.x <= in_ch.pos_x;
            pos_r.y <= in_ch.pos_y;
            pos_r.z <= in_ch.pos_z;
            ca_r    <= in_ch.corner_a;
            cb_r    <= in_ch.corner_b;
            cc_r    <= in_ch.corner_c;
            rstat_r <= idle_err ? svn_pkg::STAT_ERR : svn_pkg::STAT_OK;
            rn_r    <= '0;
            rasg_r  <= '0;
            case (in_ch.command)
              svn_pkg::CMD_LOAD:  state_r <= S_LOAD;
              svn_pkg::CMD_TRI:   state_r <= tri_ok ? S_TRA : S_DONE;
              svn_pkg::CMD_QUERY: state_r <= qry_ok ? S_QRD : S_DONE;
              default: begin
                cnt_r   <= '0;
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_LOAD: begin
          if (pos_we) begin
            rasg_r <= cnt_r[IW-1:0];
            cnt_r  <= cnt_r + CW'(1);
          end else begin
            rstat_r <= svn_pkg::STAT_ERR;
          end
          state_r <= S_DONE;
        end
        S_TRA: state_r <= S_TRB;
        S_TRB: begin
          pa_r    <= pos_rd;
          state_r <= S_TRC;
        end
        S_TRC: begin
          pb_r    <= pos_rd;
          state_r <= S_TRD;
        end
        S_TRD: state_r <= S_CROSS;
        S_CROSS: begin
          if (cross_done) begin
            state_r <= S_TNORM;
          end
        end
        S_TNORM: begin
          if (norm_done) begin
            rstat_r <= norm_res.status;
            rn_r    <= norm_res.nrm;
            // A degenerate triangle leaves the running sums alone.
            state_r <= (norm_res.status == svn_pkg::STAT_OK) ? S_URA : S_DONE;
          end
        end
        S_URA: state_r <= S_UWA;
        S_UWA: state_r <= S_URB;
        S_URB: state_r <= S_UWB;
        S_UWB: state_r <= S_URC;
        S_URC: state_r <= S_UWC;
        S_UWC: state_r <= S_DONE;
        S_QRD: state_r <= S_QCAP;
        S_QCAP: state_r <= S_QNORM;
        S_QNORM: begin
          if (norm_done) begin
            rstat_r <= norm_res.status;
            rn_r    <= norm_res.nrm;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            ostat_r     <= rstat_r;
            on_r        <= rn_r;
            oasg_r      <= rasg_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  svn_ram #(
    .WIDTH (3 * svn_pkg::POS_W),
    .DEPTH (VCAP)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (pos_r),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  svn_ram #(
    .WIDTH (3 * svn_pkg::SUM_W),
    .DEPTH (VCAP)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wd),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  svn_cross u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cross_start),
    .pa    (pa_r),
    .pb    (pb_r),
    .pc    (pos_rd),
    .done  (cross_done),
    .xprod (cross_vec)
  );

  svn_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vec_i (norm_vec),
    .done  (norm_done),
    .res   (norm_res)
  );

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = ostat_r;
  assign out_ch.normal_x       = on_r.x;
  assign out_ch.normal_y       = on_r.y;
  assign out_ch.normal_z       = on_r.z;
  assign out_ch.assigned_index = oasg_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(VCAP))
    else $error("vertex count beyond store capacity");

  a_cross_done: assert property (@(posedge clk) disable iff (!rst_n)
    cross_done |-> (state_r == S_CROSS))
    else $error("cross product finished outside its wait state");

  a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> (state_r == S_TNORM || state_r == S_QNORM))
    else $error("normaliser finished outside a wait state");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.command == svn_pkg::CMD_CLEAR) |=> (cnt_r == '0))
    else $error("clear item did not empty the vertex store");

endmodule
`default_nettype wire

// File: rtl/core/svn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module svn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/core/svn_cross.sv
// Edge cross product on one shared 17x17 multiplier, one product per cycle.
`timescale 1ns / 1ps
`default_nettype none
module svn_cross (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire svn_pkg::vec16_t pa,
  input  wire svn_pkg::vec16_t pb,
  input  wire svn_pkg::vec16_t pc,
  output logic                 done,
  output svn_pkg::vec_t        xprod
);

  localparam logic [2:0] LAST_STEP = 3'd6;

  logic              busy_r;
  logic              done_r;
  logic [2:0]        step_r;
  logic signed [16:0] e1_r [3];
  logic signed [16:0] e2_r [3];
  logic signed [33:0] prod_r;
  logic signed [35:0] x_r [3];
  logic signed [16:0] op_a;
  logic signed [16:0] op_b;
  logic [2:0]         acc_step;

  // Product order: y*z, z*y, z*x, x*z, x*y, y*x; each even product starts a component.
  always_comb begin
    case (step_r)
      3'd0:    begin op_a = e1_r[1]; op_b = e2_r[2]; end
      3'd1:    begin op_a = e1_r[2]; op_b = e2_r[1]; end
      3'd2:    begin op_a = e1_r[2]; op_b = e2_r[0]; end
      3'd3:    begin op_a = e1_r[0]; op_b = e2_r[2]; end
      3'd4:    begin op_a = e1_r[0]; op_b = e2_r[1]; end
      3'd5:    begin op_a = e1_r[1]; op_b = e2_r[0]; end
      default: begin op_a = '0;      op_b = '0;      end
    endcase
  end

  assign acc_step = step_r - 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == LAST_STEP);
      if (start && !busy_r) begin
        busy_r  <= 1'b1;
        step_r  <= '0;
        e1_r[0] <= {pb.x[15], pb.x} - {pa.x[15], pa.x};
        e1_r[1] <= {pb.y[15], pb.y} - {pa.y[15], pa.y};
        e1_r[2] <= {pb.z[15], pb.z} - {pa.z[15], pa.z};
        e2_r[0] <= {pc.x[15], pc.x} - {pa.x[15], pa.x};
        e2_r[1] <= {pc.y[15], pc.y} - {pa.y[15], pa.y};
        e2_r[2] <= {pc.z[15], pc.z} - {pa.z[15], pa.z};
      end else if (busy_r) begin
        prod_r <= op_a * op_b;
        if (step_r != 3'd0) begin
          if (!acc_step[0]) begin
            x_r[acc_step[2:1]] <= {{2{prod_r[33]}}, prod_r};
          end else begin
            x_r[acc_step[2:1]] <= x_r[acc_step[2:1]] - {{2{prod_r[33]}}, prod_r};
          end
        end
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
        step_r <= step_r + 3'd1;
      end
    end
  end

  assign done    = done_r;
  assign xprod.x = x_r[0];
  assign xprod.y = x_r[1];
  assign xprod.z = x_r[2];

endmodule
`default_nettype wire

// File: rtl/core/svn_norm.sv
// Shared normaliser: scales a vector to a Q1.14 unit vector with exact rounding.
`timescale 1ns / 1ps
`default_nettype none
module svn_norm (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire svn_pkg::vec_t vec_i,
  output logic               done,
  output svn_pkg::norm_res_t res
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SUM   = 3'd3;
  localparam logic [2:0] N_SINIT = 3'd4;
  localparam logic [2:0] N_SRCH  = 3'd5;

  logic [2:0]          state_r;
  logic                done_r;
  logic [2:0]          neg_r;
  logic [35:0]         mag_r [3];
  logic [31:0]         sq_r [3];
  logic [33:0]         s_r;
  logic [1:0]          idx_r;
  logic [14:0]         bit_r;
  logic [14:0]         q_r;
  logic signed [71:0]  p_r;
  logic signed [71:0]  qk_r;
  logic signed [71:0]  sa_r;
  logic [61:0]         lim_r;
  logic [15:0]         res_r [3];
  logic [1:0]          stat_r;

  logic signed [35:0]  vin [3];
  logic                big_hi;
  logic                all_zero;
  logic signed [71:0]  p_try;
  logic                fits;
  logic [14:0]         q_fin;
  logic [15:0]         q_ext;
  logic [15:0]         q_sgn;
  logic [31:0]         sq_prod;
  logic signed [71:0]  qk_upd;

  assign vin[0] = vec_i.x;
  assign vin[1] = vec_i.y;
  assign vin[2] = vec_i.z;

  assign big_hi   = (|mag_r[0][35:16]) | (|mag_r[1][35:16]) | (|mag_r[2][35:16]);
  assign all_zero = (mag_r[0] == '0) && (mag_r[1] == '0) && (mag_r[2] == '0);
  assign sq_prod  = mag_r[idx_r][15:0] * mag_r[idx_r][15:0];

  // Trial of the next quotient bit: t = 2q - 1 grows by 2b, so t^2*S grows by
  // (t*S << (k+2)) + (S << (2k+2)); both terms are kept pre-shifted.
  assign p_try  = p_r + qk_r + sa_r;
  assign fits   = p_try <= $signed({10'd0, lim_r});
  assign q_fin  = fits ? (q_r | bit_r) : q_r;
  assign q_ext  = {1'b0, q_fin};
  assign q_sgn  = neg_r[idx_r] ? (~q_ext + 16'd1) : q_ext;
  assign qk_upd = fits ? (qk_r + (sa_r <<< 1)) : qk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= ((state_r == N_SHIFT) && all_zero) ||
                ((state_r == N_SRCH) && bit_r[0] && (idx_r == 2'd2));
      case (state_r)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg_r[i] <= vin[i][35];
              mag_r[i] <= vin[i][35] ? 36'(-vin[i]) : 36'(vin[i]);
            end
            state_r <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (all_zero) begin
            stat_r   <= svn_pkg::STAT_ZERO;
            res_r[0] <= '0;
            res_r[1] <= '0;
            res_r[2] <= '0;
            state_r  <= N_IDLE;
          end else if (big_hi) begin
            for (int i = 0; i < 3; i++) begin
              mag_r[i] <= mag_r[i] >> 1;
            end
          end else begin
            idx_r   <= '0;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          sq_r[idx_r] <= sq_prod;
          if (idx_r == 2'd2) begin
            state_r <= N_SUM;
          end else begin
            idx_r <= idx_r + 2'd1;
          end
        end
        N_SUM: begin
          s_r     <= {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
          idx_r   <= '0;
          state_r <= N_SINIT;
        end
        N_SINIT: begin
          p_r     <= $signed({38'd0, s_r});
          qk_r    <= -($signed({38'd0, s_r}) <<< 16);
          sa_r    <= $signed({8'd0, s_r, 30'd0});
          lim_r   <= {sq_r[idx_r], 30'd0};
          bit_r   <= 15'h4000;
          q_r     <= '0;
          state_r <= N_SRCH;
        end
        N_SRCH: begin
          if (fits) begin
            p_r <= p_try;
          end
          q_r   <= q_fin;
          qk_r  <= qk_upd >>> 1;
          sa_r  <= sa_r >>> 2;
          bit_r <= bit_r >> 1;
          if (bit_r[0]) begin
            res_r[idx_r] <= q_sgn;
            if (idx_r == 2'd2) begin
              stat_r  <= svn_pkg::STAT_OK;
              state_r <= N_IDLE;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= N_SINIT;
            end
          end
        end
        default: begin
          state_r <= N_IDLE;
        end
      endcase
    end
  end

  assign done       = done_r;
  assign res.status = stat_r;
  assign res.nrm.x  = res_r[0];
  assign res.nrm.y  = res_r[1];
  assign res.nrm.z  = res_r[2];

endmodule
`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the smooth vertex normal unit: directed and random meshes.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  typedef struct {
    logic [1:0]        command;
    logic signed [15:0] px, py, pz;
    logic [9:0]        ca, cb, cc;
  } mesh_item_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [15:0] nx, ny, nz;
    logic [9:0]         idx;
  } normal_res_t;

  class normal_scoreboard;
    logic signed [15:0] pos_x[svn_pkg::IDX_CAP], pos_y[svn_pkg::IDX_CAP];
    logic signed [15:0] pos_z[svn_pkg::IDX_CAP];
    longint             sum_x[svn_pkg::IDX_CAP], sum_y[svn_pkg::IDX_CAP];
    longint             sum_z[svn_pkg::IDX_CAP];
    int unsigned        vcount;
    normal_res_t        due[$];
    int                 mismatches;

    function new();
      vcount = 0;
      mismatches = 0;
      for (int i = 0; i < svn_pkg::IDX_CAP; i++) begin
        sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
      end
    endfunction

    // Exact round-half-up of 16384 * m / sqrt(S) by a search on the square.
    function normal_res_t unit_normal(longint vx, longint vy, longint vz);
      normal_res_t r;
      logic [63:0] mag[3], big, s, lim, lo, hi, mid, t;
      bit          neg[3];
      longint      v[3];
      logic signed [15:0] q[3];
      v[0] = vx; v[1] = vy; v[2] = vz;
      big = 0;
      r = '{svn_pkg::STAT_OK, 16'sd0, 16'sd0, 16'sd0, 10'd0};
      for (int i = 0; i < 3; i++) begin
        neg[i] = v[i] < 0;
        mag[i] = neg[i] ? -v[i] : v[i];
        if (mag[i] > big) big = mag[i];
      end
      if (big == 0) begin
        r.status = svn_pkg::STAT_ZERO;
        return r;
      end
      while (big >= 64'd65536) begin
        big = big >> 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      s = 0;
      for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
      for (int i = 0; i < 3; i++) begin
        lo = 0; hi = 16384;
        lim = (mag[i] * mag[i]) << 30;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          t = 2 * mid - 1;
          if (t * t * s <= lim) lo = mid;
          else hi = mid - 1;
        end
        q[i] = neg[i] ? -$signed(lo[15:0]) : $signed(lo[15:0]);
      end
      r.nx = q[0]; r.ny = q[1]; r.nz = q[2];
      return r;
    endfunction

    function longint clamp32(longint a);
      if (a > 64'sd2147483647) return 64'sd2147483647;
      if (a < -64'sd2147483648) return -64'sd2147483648;
      return a;
    endfunction

    function void note_item(mesh_item_t it);
      normal_res_t r;
      longint e1[3], e2[3], x, y, z;
      r = '{svn_pkg::STAT_OK, 16'sd0, 16'sd0, 16'sd0, 10'd0};
      case (it.command)
        svn_pkg::CMD_LOAD: begin
          if (vcount >= svn_pkg::IDX_CAP) begin
            r.status = svn_pkg::STAT_ERR;
          end else begin
            pos_x[vcount] = it.px; pos_y[vcount] = it.py; pos_z[vcount] = it.pz;
            r.idx = vcount[9:0];
            vcount++;
          end
        end
        svn_pkg::CMD_TRI: begin
          if (it.ca >= vcount || it.cb >= vcount || it.cc >= vcount) begin
            r.status = svn_pkg::STAT_ERR;
          end else begin
            e1[0] = longint'(pos_x[it.cb]) - pos_x[it.ca];
            e1[1] = longint'(pos_y[it.cb]) - pos_y[it.ca];
            e1[2] = longint'(pos_z[it.cb]) - pos_z[it.ca];
            e2[0] = longint'(pos_x[it.cc]) - pos_x[it.ca];
            e2[1] = longint'(pos_y[it.cc]) - pos_y[it.ca];
            e2[2] = longint'(pos_z[it.cc]) - pos_z[it.ca];
            x = e1[1] * e2[2] - e1[2] * e2[1];
            y = e1[2] * e2[0] - e1[0] * e2[2];
            z = e1[0] * e2[1] - e1[1] * e2[0];
            r = unit_normal(x, y, z);
            if (r.status == svn_pkg::STAT_OK) begin
              sum_x[it.ca] = clamp32(sum_x[it.ca] + r.nx);
              sum_y[it.ca] = clamp32(sum_y[it.ca] + r.ny);
              sum_z[it.ca] = clamp32(sum_z[it.ca] + r.nz);
              sum_x[it.cb] = clamp32(sum_x[it.cb] + r.nx);
              sum_y[it.cb] = clamp32(sum_y[it.cb] + r.ny);
              sum_z[it.cb] = clamp32(sum_z[it.cb] + r.nz);
              sum_x[it.cc] = clamp32(sum_x[it.cc] + r.nx);
              sum_y[it.cc] = clamp32(sum_y[it.cc] + r.ny);
              sum_z[it.cc] = clamp32(sum_z[it.cc] + r.nz);
            end
          end
        end
        svn_pkg::CMD_QUERY: begin
          if (it.ca >= vcount) r.status = svn_pkg::STAT_ERR;
          else r = unit_normal(sum_x[it.ca], sum_y[it.ca], sum_z[it.ca]);
        end
        default: begin
          for (int i = 0; i < svn_pkg::IDX_CAP; i++) begin
            sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
          end
          vcount = 0;
        end
      endcase
      due.insert(due.size(), r);
    endfunction

    function void check_result(normal_res_t got);
      normal_res_t exp_r;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", got.status);
        return;
      end
      exp_r = due.pop_front();
      if (got.status !== exp_r.status || got.nx !== exp_r.nx || got.ny !== exp_r.ny ||
          got.nz !== exp_r.nz || got.idx !== exp_r.idx) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected st=%0d n=(%0d,%0d,%0d) idx=%0d, %s",
                   exp_r.status, exp_r.nx, exp_r.ny, exp_r.nz, exp_r.idx,
                   $sformatf("got st=%0d n=(%0d,%0d,%0d) idx=%0d",
                             got.status, got.nx, got.ny, got.nz, got.idx));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  svn_in_if  in_ch();
  svn_out_if out_ch();

  smooth_vertex_normals_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  normal_scoreboard sb;
  bit     quiet;
  int     sent;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 1000000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side: random ready bursts, checking every accepted item.
  initial begin
    int          burst;
    normal_res_t got;
    burst = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.nx = out_ch.normal_x;
        got.ny = out_ch.normal_y;
        got.nz = out_ch.normal_z;
        got.idx = out_ch.assigned_index;
        sb.check_result(got);
      end
      if (quiet) begin
        out_ch.ready <= 1'b1;
      end else if (burst == 0) begin
        burst = $urandom_range(1, 16);
        out_ch.ready <= ($urandom_range(0, 2) != 0);
      end else begin
        burst--;
      end
    end
  end

  task automatic send_item(mesh_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= it.command;
    in_ch.pos_x    <= it.px;
    in_ch.pos_y    <= it.py;
    in_ch.pos_z    <= it.pz;
    in_ch.corner_a <= it.ca;
    in_ch.corner_b <= it.cb;
    in_ch.corner_c <= it.cc;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
    sent++;
  endtask

  function automatic mesh_item_t mk(logic [1:0] cmd, int x, int y, int z, int a, int b, int c);
    mesh_item_t it;
    it.command = cmd;
    it.px = 16'(x); it.py = 16'(y); it.pz = 16'(z);
    it.ca = 10'(a); it.cb = 10'(b); it.cc = 10'(c);
    return it;
  endfunction

  function automatic mesh_item_t rand_load(bit narrow);
    if (narrow)
      return mk(svn_pkg::CMD_LOAD, $urandom_range(0, 2047) - 1024,
                $urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                $urandom, $urandom, $urandom);
    return mk(svn_pkg::CMD_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic int pick_corner(int unsigned n);
    if (n == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, n - 1);
  endfunction

  initial begin
    int unsigned nv;
    int          nops, r;
    bit          narrow;
    sb = new();
    quiet = 0;
    sent = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= svn_pkg::CMD_CLEAR;
    in_ch.pos_x <= '0; in_ch.pos_y <= '0; in_ch.pos_z <= '0;
    in_ch.corner_a <= '0; in_ch.corner_b <= '0; in_ch.corner_c <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, extremes, degenerate and collinear triangles, zero sums.
    send_item(mk(svn_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0));
    send_item(mk(svn_pkg::CMD_TRI, 0, 0, 0, 0, 0, 0));
    send_item(mk(svn_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0));
    send_item(mk(svn_pkg::CMD_LOAD, 256, 0, 0, 0, 0, 0));
    send_item(mk(svn_pkg::CMD_LOAD, 0, 256, 0, 0, 0, 0));
    send_item(mk(svn_pkg::CMD_LOAD, 32767, 32767, 32767, 0, 0, 0));
    send_item(mk(svn_pkg::CMD_LOAD, -32768, -32768, -32768, 0, 0, 0));
    send_item(mk(svn_pkg::CMD_LOAD, 32767, -32768, 0, 0, 0, 0));
    send_item(mk(svn_pkg::CMD_TRI, 0, 0, 0, 0, 1, 2));
    send_item(mk(svn_pkg::CMD_TRI, 0, 0, 0, 0, 0, 1));
    send_item(mk(svn_pkg::CMD_TRI, 0, 0, 0, 0, 1, 6));
    send_item(mk(svn_pkg::CMD_TRI, 0, 0, 0, 1023, 1, 2));
    send_item(mk(svn_pkg::CMD_TRI, 0, 0, 0, 3, 4, 5));
    send_item(mk(svn_pkg::CMD_TRI, 0, 0, 0, 0, 4, 5));
    send_item(mk(svn_pkg::CMD_LOAD, 512, 0, 0, 0, 0, 0));
    send_item(mk(svn_pkg::CMD_TRI, 0, 0, 0, 0, 1, 6));
    send_item(mk(svn_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0));
    send_item(mk(svn_pkg::CMD_QUERY, 0, 0, 0, 3, 0, 0));
    send_item(mk(svn_pkg::CMD_QUERY, 0, 0, 0, 6, 0, 0));
    send_item(mk(svn_pkg::CMD_QUERY, 0, 0, 0, 7, 0, 0));
    send_item(mk(svn_pkg::CMD_QUERY, 0, 0, 0, 1023, 0, 0));
    send_item(mk(svn_pkg::CMD_CLEAR, -1, -1, -1, 1023, 1023, 1023));
    send_item(mk(svn_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0));

    // Hold the sender until the block has drained.
    in_ch.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);

    // Random meshes; the third one fills the store past its capacity.
    for (int ph = 0; sent < 1250 || ph < 4; ph++) begin
      if (sent > 1150) quiet = 1;
      if ($urandom_range(0, 4) != 0 || ph == 2)
        send_item(mk(svn_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom));
      narrow = 1'($urandom_range(0, 1));
      nv = (ph == 2) ? svn_pkg::IDX_CAP + 2 : $urandom_range(3, 30);
      for (int i = 0; i < nv; i++) send_item(rand_load(narrow));
      nops = $urandom_range(10, 40);
      for (int i = 0; i < nops; i++) begin
        r = $urandom_range(0, 19);
        if (r < 11)
          send_item(mk(svn_pkg::CMD_TRI, $urandom, $urandom, $urandom, pick_corner(sb.vcount),
                       pick_corner(sb.vcount), pick_corner(sb.vcount)));
        else if (r < 17)
          send_item(mk(svn_pkg::CMD_QUERY, $urandom, $urandom, $urandom,
                       pick_corner(sb.vcount), $urandom, $urandom));
        else if (r < 19)
          send_item(rand_load(1'($urandom_range(0, 1))));
        else
          send_item(mk(2'($urandom_range(0, 2)), $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom));
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
rtl/core/svn_pkg.sv
rtl/core/svn_if.sv
rtl/core/svn_ram.sv
rtl/core/svn_cross.sv
rtl/core/svn_norm.sv
rtl/core/smooth_vertex_normals_unit.sv
bench/testbench.sv
